/* design/linear_array_deque_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear array deque
// Concurrent checks on the clock and reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef LINEAR_ARRAY_DEQUE_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LADQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define LADQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LADQ_ASSERT_NOW(lbl, ante, cons, msg)
`define LADQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/ladq_pkg.sv */
// ----------------------------------------------------------------------------
// ladq_pkg
// Opcodes, status codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ladq_pkg;

   localparam int OpW   = 3;
   localparam int WordW = 32;
   localparam int StW   = 3;

   localparam logic [OpW-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OpW-1:0] OP_DEL_FRONT = 3'd1;
   localparam logic [OpW-1:0] OP_INS_REAR  = 3'd2;
   localparam logic [OpW-1:0] OP_DEL_REAR  = 3'd3;
   localparam logic [OpW-1:0] OP_LIST      = 3'd4;

   localparam logic [StW-1:0] ST_OK        = 3'd0;
   localparam logic [StW-1:0] ST_FULL_REAR = 3'd1;
   localparam logic [StW-1:0] ST_NO_FRONT  = 3'd2;
   localparam logic [StW-1:0] ST_EMPTY     = 3'd3;
   localparam logic [StW-1:0] ST_BAD_OP    = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LIST = 2'b10
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic walk;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic list_go;
      logic walk_last;
   } dp_stat_type;

endpackage

/* design/ladq_ctrl.sv */
// ----------------------------------------------------------------------------
// ladq_ctrl
// Controller: accepts transactions and sequences the listing walk.
// ----------------------------------------------------------------------------
`include "linear_array_deque_macros.svh"

module ladq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ladq_pkg::dp_stat_type stat,
   output ladq_pkg::ctrl_cmd_type cmd
);

   ladq_pkg::state_type state_ff;
   ladq_pkg::state_type state_in;

   assign busy       = (state_ff == ladq_pkg::S_LIST);
   assign cmd.accept = start && !busy;
   assign cmd.walk   = (state_ff == ladq_pkg::S_LIST);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ladq_pkg::S_IDLE: begin
            if (cmd.accept && stat.list_go) begin
               state_in = ladq_pkg::S_LIST;
            end
         end
         ladq_pkg::S_LIST: begin
            if (stat.walk_last) begin
               state_in = ladq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ladq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ladq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LADQ_ASSERT_NEXT(a_walk_continues, (state_ff == ladq_pkg::S_LIST) && !stat.walk_last, state_ff == ladq_pkg::S_LIST, "listing walk ended early")
   `LADQ_ASSERT_NEXT(a_list_enters_walk, cmd.accept && stat.list_go, state_ff == ladq_pkg::S_LIST, "list transaction did not start a walk")

endmodule

/* design/ladq_dp.sv */
// ----------------------------------------------------------------------------
// ladq_dp
// Datapath: slot memory, head and tail indices, result registers.
// ----------------------------------------------------------------------------
`include "linear_array_deque_macros.svh"

module ladq_dp #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [ladq_pkg::OpW-1:0]             req_opcode,
   input  logic signed [ladq_pkg::WordW-1:0]    req_data_word,
   input  ladq_pkg::ctrl_cmd_type               cmd,
   output ladq_pkg::dp_stat_type                stat,
   output logic                                 rsp_strobe,
   output logic [ladq_pkg::StW-1:0]             rsp_status,
   output logic signed [ladq_pkg::WordW-1:0]    rsp_element_value,
   output logic                                 rsp_last_result
);

   localparam int IdxW = $clog2(DEPTH);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
   localparam logic [IdxW-1:0] One = IdxW'(1);

   logic [ladq_pkg::WordW-1:0] slot_store_ff [DEPTH];
   logic [ladq_pkg::WordW-1:0] rd_data_ff;
   logic [IdxW-1:0]            rd_addr;

   logic [IdxW-1:0]            head_ff, head_in;
   logic [IdxW-1:0]            tail_ff, tail_in;
   logic                       empty_ff, empty_in;
   logic [IdxW-1:0]            walk_ff, walk_in;
   logic                       single_ff, single_in;
   logic [ladq_pkg::StW-1:0]   status_ff, status_in;

   logic                       wr_en;
   logic [IdxW-1:0]            wr_addr;
   logic                       list_ok;
   logic                       walk_last;

   assign list_ok      = !empty_ff && (head_ff <= tail_ff);
   assign walk_last    = (walk_ff == tail_ff);
   assign stat.list_go = (req_opcode == ladq_pkg::OP_LIST) && list_ok;
   assign stat.walk_last = walk_last;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = ladq_pkg::ST_OK;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      case (req_opcode)
         ladq_pkg::OP_INS_FRONT: begin
            if (empty_ff) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
            end else if (head_ff == '0) begin
               status_in = ladq_pkg::ST_NO_FRONT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = head_ff - One;
               head_in = head_ff - One;
            end
         end
         ladq_pkg::OP_DEL_FRONT: begin
            if (empty_ff) begin
               status_in = ladq_pkg::ST_EMPTY;
            end else if (head_ff >= tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else begin
               head_in = head_ff + One;
            end
         end
         ladq_pkg::OP_INS_REAR: begin
            if (empty_ff) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b0;
            end else if (tail_ff >= LastIdx) begin
               status_in = ladq_pkg::ST_FULL_REAR;
            end else begin
               wr_en   = 1'b1;
               wr_addr = tail_ff + One;
               tail_in = tail_ff + One;
            end
         end
         ladq_pkg::OP_DEL_REAR: begin
            if (empty_ff) begin
               status_in = ladq_pkg::ST_EMPTY;
            end else if (tail_ff <= head_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else begin
               tail_in = tail_ff - One;
            end
         end
         ladq_pkg::OP_LIST: begin
            if (!list_ok) begin
               status_in = ladq_pkg::ST_EMPTY;
            end
         end
         default: begin
            status_in = ladq_pkg::ST_BAD_OP;
         end
      endcase
   end

   // A list that has entries produces its results from the walk, not here.
   assign single_in = cmd.accept && !stat.list_go;

   // The read is issued in the cycle before the result that shows it.
   assign rd_addr = (cmd.walk && !walk_last) ? walk_ff + One : head_ff;
   assign walk_in = cmd.walk ? ((walk_last) ? walk_ff : walk_ff + One) : head_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && wr_en) begin
         slot_store_ff[wr_addr] <= req_data_word;
      end
      rd_data_ff <= slot_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (cmd.accept) begin
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         empty_ff  <= 1'b1;
         single_ff <= 1'b0;
      end else begin
         single_ff <= single_in;
         if (cmd.accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            empty_ff <= empty_in;
         end
      end
   end

   assign rsp_strobe        = single_ff || cmd.walk;
   assign rsp_status        = cmd.walk ? ladq_pkg::ST_OK : status_ff;
   assign rsp_element_value = cmd.walk ? rd_data_ff : '0;
   assign rsp_last_result   = cmd.walk ? walk_last : 1'b1;

   `LADQ_ASSERT_NOW(a_order, !empty_ff, head_ff <= tail_ff, "head index passed tail index")
   `LADQ_ASSERT_NOW(a_empty_idx, empty_ff, (head_ff == '0) && (tail_ff == '0), "empty queue with nonzero index")
   `LADQ_ASSERT_NOW(a_one_source, 1'b1, !(single_ff && cmd.walk), "two results in one cycle")

endmodule

/* design/linear_array_deque.sv */
// ----------------------------------------------------------------------------
// linear_array_deque
// Double-ended queue in a fixed, non-circular array of signed words.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Insert, delete
// and invalid-opcode transactions show their single result on the cycle after
// acceptance, so they can be issued back to back. A list transaction on a
// non-empty queue walks the slot memory one entry per cycle through its single
// registered read port: results appear from the cycle after acceptance, one per
// stored word from head to tail, and busy stays high through the result for
// the tail entry. The result strobe lasts one cycle and the receiver cannot
// stall it, so it must take every result as it comes.
// ----------------------------------------------------------------------------
module linear_array_deque #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ladq_pkg::OpW-1:0]          req_opcode,
   input  logic signed [ladq_pkg::WordW-1:0] req_data_word,
   output logic                              rsp_strobe,
   output logic [ladq_pkg::StW-1:0]          rsp_status,
   output logic signed [ladq_pkg::WordW-1:0] rsp_element_value,
   output logic                              rsp_last_result
);

   ladq_pkg::ctrl_cmd_type cmd;
   ladq_pkg::dp_stat_type  stat;

   ladq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ladq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_data_word     (req_data_word),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

/* test/tb_linear_array_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_array_deque
// Drives opcode and data transactions into the deque, predicts every result
// from a behavioral copy of the queue state, and compares each strobed result
// field by field. A short table of directed rows is followed by a fill to the
// rear limit and a long random run with occasional idle gaps.
// ----------------------------------------------------------------------------
module tb_linear_array_deque;

   localparam int DEPTH       = 64;
   localparam int RANDOM_ITEMS = 280;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int WORD_W      = ladq_pkg::WordW;

   // Opcodes the block must reject.
   localparam logic [ladq_pkg::OpW-1:0] OP_RSVD5 = 3'd5;
   localparam logic [ladq_pkg::OpW-1:0] OP_RSVD6 = 3'd6;
   localparam logic [ladq_pkg::OpW-1:0] OP_RSVD7 = 3'd7;

   typedef struct {
      logic [ladq_pkg::StW-1:0]          status;
      logic signed [ladq_pkg::WordW-1:0] value;
      logic                              last;
   } deque_rsp_type;

   typedef struct {
      logic [ladq_pkg::OpW-1:0]          op;
      logic signed [ladq_pkg::WordW-1:0] word;
      bit                                typed;
      logic [ladq_pkg::StW-1:0]          status;
   } stim_row_type;

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [ladq_pkg::OpW-1:0]          req_opcode = ladq_pkg::OP_INS_FRONT;
   logic signed [ladq_pkg::WordW-1:0] req_data_word = '0;
   logic                              rsp_strobe;
   logic [ladq_pkg::StW-1:0]          rsp_status;
   logic signed [ladq_pkg::WordW-1:0] rsp_element_value;
   logic                              rsp_last_result;

   // Shadow copy of the queue contents and indices.
   logic signed [ladq_pkg::WordW-1:0] shadow_slots [DEPTH];
   logic [5:0]                        shadow_head = '0;
   logic [5:0]                        shadow_tail = '0;
   bit                                shadow_empty = 1'b1;

   deque_rsp_type step_rsps [$];
   deque_rsp_type pending_rsps [$];
   stim_row_type  directed_rows [$];
   bit            failed = 1'b0;
   int            cycle_count = 0;

   linear_array_deque #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_data_word     (req_data_word),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_element_value (rsp_element_value),
      .rsp_last_result   (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linear_array_deque test failed");
         $finish;
      end
   end

   task automatic push_rsp(input logic [ladq_pkg::StW-1:0] status,
                           input logic signed [ladq_pkg::WordW-1:0] value,
                           input logic last);
      deque_rsp_type r;
      r.status = status;
      r.value  = value;
      r.last   = last;
      step_rsps.push_back(r);
   endtask

   // Updates the shadow queue for one transaction and collects its results.
   task automatic predict_deque_op(input logic [ladq_pkg::OpW-1:0] op,
                                   input logic signed [ladq_pkg::WordW-1:0] word);
      logic [ladq_pkg::StW-1:0] status;
      status = ladq_pkg::ST_OK;
      step_rsps.delete();
      case (op)
         ladq_pkg::OP_INS_FRONT, ladq_pkg::OP_INS_REAR: begin
            if (shadow_empty) begin
               shadow_slots[0] = word;
               shadow_head = '0;
               shadow_tail = '0;
               shadow_empty = 1'b0;
            end else if (op == ladq_pkg::OP_INS_FRONT) begin
               if (shadow_head == 0) status = ladq_pkg::ST_NO_FRONT;
               else begin
                  shadow_head = shadow_head - 1'b1;
                  shadow_slots[shadow_head] = word;
               end
            end else if (shadow_tail >= DEPTH - 1) begin
               status = ladq_pkg::ST_FULL_REAR;
            end else begin
               shadow_tail = shadow_tail + 1'b1;
               shadow_slots[shadow_tail] = word;
            end
         end
         ladq_pkg::OP_DEL_FRONT, ladq_pkg::OP_DEL_REAR: begin
            if (shadow_empty) status = ladq_pkg::ST_EMPTY;
            else if (shadow_head >= shadow_tail) begin
               shadow_empty = 1'b1;
               shadow_head = '0;
               shadow_tail = '0;
            end else if (op == ladq_pkg::OP_DEL_FRONT) shadow_head = shadow_head + 1'b1;
            else shadow_tail = shadow_tail - 1'b1;
         end
         ladq_pkg::OP_LIST: begin
            if (shadow_empty || shadow_head > shadow_tail) status = ladq_pkg::ST_EMPTY;
            else begin
               for (int i = int'(shadow_head); i <= int'(shadow_tail); i++)
                  push_rsp(ladq_pkg::ST_OK, shadow_slots[i], i == int'(shadow_tail));
               return;
            end
         end
         default: status = ladq_pkg::ST_BAD_OP;
      endcase
      push_rsp(status, '0, 1'b1);
   endtask

   // Presents one transaction and holds it until the block takes it.
   task automatic issue(input logic [ladq_pkg::OpW-1:0] op,
                        input logic signed [ladq_pkg::WordW-1:0] word,
                        input bit typed = 1'b0,
                        input logic [ladq_pkg::StW-1:0] typed_status = ladq_pkg::ST_OK);
      deque_rsp_type r;
      start         <= 1'b1;
      req_opcode    <= op;
      req_data_word <= word;
      do @(posedge clock); while (busy !== 1'b0);
      predict_deque_op(op, word);
      if (typed) begin
         r.status = typed_status;
         r.value  = '0;
         r.last   = 1'b1;
         pending_rsps.push_back(r);
      end else begin
         foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
      end
   endtask

   task automatic maybe_idle(input bit allowed);
      if (allowed && $urandom_range(99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   function automatic logic signed [ladq_pkg::WordW-1:0] pick_word();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return 32'shFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Growth phases favor inserts, shrink phases favor deletes.
   function automatic logic [ladq_pkg::OpW-1:0] pick_op(input bit grow);
      int r;
      r = $urandom_range(99);
      if (r < (grow ? 35 : 12)) return ladq_pkg::OP_INS_REAR;
      if (r < (grow ? 55 : 22)) return ladq_pkg::OP_INS_FRONT;
      if (r < (grow ? 68 : 50)) return ladq_pkg::OP_DEL_FRONT;
      if (r < (grow ? 78 : 75)) return ladq_pkg::OP_DEL_REAR;
      if (r < (grow ? 92 : 90)) return ladq_pkg::OP_LIST;
      case ($urandom_range(2))
         0: return OP_RSVD5;
         1: return OP_RSVD6;
         default: return OP_RSVD7;
      endcase
   endfunction

   task automatic check_field(input string name, input logic signed [ladq_pkg::WordW-1:0] want,
                              input logic signed [ladq_pkg::WordW-1:0] got);
      if (got !== want) begin
         failed = 1'b1;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      deque_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            failed = 1'b1;
            $display("%0t: result with none expected, status %0d value %0d", $time,
                     rsp_status, rsp_element_value);
         end else begin
            want = pending_rsps.pop_front();
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_status));
            check_field("element_value", want.value, rsp_element_value);
            check_field("last_result", WORD_W'(want.last), WORD_W'(rsp_last_result));
         end
      end
   end

   initial begin
      directed_rows = '{
         '{ladq_pkg::OP_LIST,      32'sd0,          1'b1, ladq_pkg::ST_EMPTY},
         '{ladq_pkg::OP_DEL_FRONT, 32'sd0,          1'b1, ladq_pkg::ST_EMPTY},
         '{ladq_pkg::OP_DEL_REAR,  32'shFFFF_FFFF,  1'b1, ladq_pkg::ST_EMPTY},
         '{OP_RSVD5,               32'sh7FFF_FFFF,  1'b1, ladq_pkg::ST_BAD_OP},
         '{OP_RSVD7,               32'sh8000_0000,  1'b1, ladq_pkg::ST_BAD_OP},
         '{ladq_pkg::OP_INS_REAR,  32'sh7FFF_FFFF,  1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_INS_FRONT, 32'sh8000_0000,  1'b1, ladq_pkg::ST_NO_FRONT},
         '{ladq_pkg::OP_INS_REAR,  32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_INS_REAR,  32'shFFFF_FFFF,  1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_LIST,      32'sd0,          1'b0, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_FRONT, 32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_FRONT, 32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_FRONT, 32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_LIST,      32'sd0,          1'b1, ladq_pkg::ST_EMPTY},
         '{ladq_pkg::OP_INS_FRONT, 32'sh8000_0000,  1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_REAR,  32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_INS_REAR,  32'sd99,         1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_INS_REAR,  32'sh5555_5555,  1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_FRONT, 32'sd0,          1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_INS_FRONT, 32'shAAAA_AAAA,  1'b1, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_LIST,      32'sd0,          1'b0, ladq_pkg::ST_OK},
         '{OP_RSVD6,               32'sh5555_5555,  1'b1, ladq_pkg::ST_BAD_OP},
         '{ladq_pkg::OP_DEL_REAR,  32'sd0,          1'b0, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_DEL_REAR,  32'sd0,          1'b0, ladq_pkg::ST_OK},
         '{ladq_pkg::OP_LIST,      32'sd0,          1'b1, ladq_pkg::ST_EMPTY}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         issue(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
               directed_rows[i].status);
         maybe_idle(1'b1);
      end
      wait_all_results();
      @(posedge clock);

      // Fill from the rear until the last slot is taken, then list the full array.
      for (int k = 0; k <= DEPTH; k++) begin
         issue(ladq_pkg::OP_INS_REAR, pick_word());
         maybe_idle(1'b1);
      end
      issue(ladq_pkg::OP_LIST, pick_word());
      issue(ladq_pkg::OP_INS_FRONT, pick_word());
      issue(ladq_pkg::OP_INS_REAR, pick_word());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250) wait_all_results();
         issue(pick_op(((n / 40) % 2) == 1), pick_word());
         maybe_idle(n < 120 || n >= 220);
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed) $display("linear_array_deque test passed");
      else $display("linear_array_deque test failed");
      $finish;
   end

endmodule
